[hdl/ndsag_pkg.sv]
package ndsag_pkg;

	localparam int NAXES      = 3;
	localparam int COORD_BITS = 12;
	localparam int SIZE_W     = COORD_BITS + 1;
	localparam int REG_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int REGION_W   = 12;
	localparam int CTR_IN_W   = 16;
	localparam int SRC_W      = 36;
	localparam int DST_W      = 48;
	localparam int CNT_W      = 36;
	localparam int VOL_W      = 3 * COORD_BITS + 1;
	localparam int VOL_LO     = 18;
	localparam int BXY_W      = 2 * SIZE_W;
	localparam int DXY_W      = 2 * COORD_BITS + 1;
	localparam int MY_W       = COORD_BITS + SIZE_W;
	localparam int SXY_W      = MY_W + 1;

	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(1) << COORD_BITS;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE_Z  = 3'd5;

	typedef struct packed {
		logic                command;
		logic [REGION_W-1:0] region_index;
		logic [CTR_IN_W-1:0] center_x;
		logic [CTR_IN_W-1:0] center_y;
		logic [CTR_IN_W-1:0] center_z;
	} cmd_t;

	typedef struct packed {
		logic                  idle_flag;
		logic [SRC_W-1:0]      src_index;
		logic [DST_W-1:0]      dst_index;
		logic [COORD_BITS-1:0] src_x;
		logic [COORD_BITS-1:0] src_y;
		logic [COORD_BITS-1:0] src_z;
		logic [COORD_BITS-1:0] box_x;
		logic [COORD_BITS-1:0] box_y;
		logic [COORD_BITS-1:0] box_z;
		logic                  last_element;
	} elem_t;

	// effective sizes, already clamped and forced to 1 on unused axes
	typedef struct packed {
		logic [NAXES-1:0][SIZE_W-1:0] data_size;
		logic [NAXES-1:0][SIZE_W-1:0] box_size;
	} cfg_t;

	typedef struct packed {
		logic                             is_start;
		logic                             idle;
		logic                             last;
		logic [REGION_W-1:0]              region;
		logic [BXY_W-1:0]                 bxy;
		logic [SIZE_W-1:0]                bz;
		logic [NAXES-1:0][COORD_BITS-1:0] sc;
		logic [NAXES-1:0][COORD_BITS-1:0] off;
		logic [CNT_W-1:0]                 count;
	} beat_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [REG_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (SIZE_W'(v) > SIZE_MAX) begin
			r = SIZE_MAX;
		end else begin
			r = SIZE_W'(v);
		end
		return r;
	endfunction

endpackage

[hdl/ndsag_cfg.sv]
module ndsag_cfg #(
	parameter int DIMS = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ndsag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ndsag_pkg::REG_W-1:0]     cfg_data,
	output ndsag_pkg::cfg_t                 sizes
);
	import ndsag_pkg::*;

	logic [NAXES-1:0][REG_W-1:0] data_size_q;
	logic [NAXES-1:0][REG_W-1:0] box_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_size_q <= {13'd1, 13'd64, 13'd64};
			box_size_q  <= {13'd1, 13'd8, 13'd8};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DATA_SIZE_X: data_size_q[0] <= cfg_data;
				REG_DATA_SIZE_Y: data_size_q[1] <= cfg_data;
				REG_DATA_SIZE_Z: data_size_q[2] <= cfg_data;
				REG_BOX_SIZE_X:  box_size_q[0]  <= cfg_data;
				REG_BOX_SIZE_Y:  box_size_q[1]  <= cfg_data;
				REG_BOX_SIZE_Z:  box_size_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int d = 0; d < NAXES; d++) begin
			if (d < DIMS) begin
				sizes.data_size[d] = eff_size(data_size_q[d]);
				sizes.box_size[d]  = eff_size(box_size_q[d]);
			end else begin
				sizes.data_size[d] = SIZE_W'(1);
				sizes.box_size[d]  = SIZE_W'(1);
			end
		end
	end

endmodule

[hdl/ndsag_seq.sv]
module ndsag_seq #(
	parameter int FRAC_BITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  ndsag_pkg::cmd_t   cmd,
	input  ndsag_pkg::cfg_t   sizes,
	output logic              beat_valid,
	input  logic              beat_ready,
	output ndsag_pkg::beat_t  beat
);
	import ndsag_pkg::*;

	localparam int SUM_W = CTR_IN_W + 2;
	localparam int CEN_W = CTR_IN_W - FRAC_BITS + 2;
	localparam int ORG_W = ((CEN_W > SIZE_W) ? CEN_W : SIZE_W) + 1;
	localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'((1 << FRAC_BITS) >> 1);

	logic                             v_s1;
	cmd_t                             cmd_s1;
	logic                             v_s2;
	beat_t                            beat_s2;

	logic                             active_q;
	logic [NAXES-1:0][COORD_BITS-1:0] origin_q;
	logic [NAXES-1:0][COORD_BITS-1:0] offset_q;
	logic [CNT_W-1:0]                 count_q;

	logic                             take_s2;
	logic                             leave_s1;
	logic                             is_start;
	logic [NAXES-1:0][CTR_IN_W-1:0]   ctr;
	logic [NAXES-1:0][COORD_BITS-1:0] new_origin;
	logic [NAXES-1:0][COORD_BITS-1:0] sc;
	logic [NAXES-1:0][COORD_BITS-1:0] next_off;
	logic [NAXES-1:0]                 notend;
	logic                             last;
	logic [BXY_W-1:0]                 bxy;
	beat_t                            beat_d;

	assign take_s2   = !v_s2 || beat_ready;
	assign leave_s1  = v_s1 && take_s2;
	assign cmd_ready = !v_s1 || leave_s1;
	assign is_start  = (cmd_s1.command == CMD_START);
	assign ctr       = {cmd_s1.center_z, cmd_s1.center_y, cmd_s1.center_x};
	assign bxy       = sizes.box_size[0] * sizes.box_size[1];

	// box origin: round center half up, go one-based, back off half the box, fit in data
	always_comb begin
		logic [SUM_W-1:0] rnd;
		logic [CEN_W-1:0] cen;
		logic [ORG_W-1:0] c_ext, b, ds, hb, org;
		for (int d = 0; d < NAXES; d++) begin
			rnd   = {2'b00, ctr[d]} + HALF_LSB;
			cen   = CEN_W'(rnd >> FRAC_BITS) + CEN_W'(1);
			c_ext = ORG_W'(cen);
			b     = ORG_W'(sizes.box_size[d]);
			ds    = ORG_W'(sizes.data_size[d]);
			hb    = (b + ORG_W'(1)) >> 1;
			org   = (c_ext > hb) ? c_ext - hb : '0;
			if (org + b > ds - ORG_W'(1)) begin
				org = (ds > b) ? ds - b : '0;
			end
			new_origin[d] = COORD_BITS'(org);
		end
	end

	// column-major walk: axis zero fastest, carry into the next axis on wrap
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int d = 0; d < NAXES; d++) begin
			notend[d] = (SIZE_W'(offset_q[d]) + SIZE_W'(1)) < sizes.box_size[d];
			sc[d]     = origin_q[d] + offset_q[d];
			next_off[d] = offset_q[d];
			if (carry) begin
				if (notend[d]) begin
					next_off[d] = offset_q[d] + COORD_BITS'(1);
					carry = 1'b0;
				end else begin
					next_off[d] = '0;
				end
			end
		end
		last = ~|notend;
	end

	always_comb begin
		beat_d = '0;
		if (is_start) begin
			beat_d.is_start = 1'b1;
			beat_d.region   = cmd_s1.region_index;
			beat_d.bxy      = bxy;
			beat_d.bz       = sizes.box_size[2];
		end else if (active_q) begin
			beat_d.last  = last;
			beat_d.sc    = sc;
			beat_d.off   = offset_q;
			beat_d.count = count_q;
		end else begin
			beat_d.idle = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			active_q <= 1'b0;
			origin_q <= '0;
			offset_q <= '0;
			count_q  <= '0;
		end else begin
			if (cmd_ready) begin
				v_s1 <= cmd_valid;
			end
			if (take_s2) begin
				v_s2 <= leave_s1;
			end
			if (leave_s1) begin
				if (is_start) begin
					origin_q <= new_origin;
					offset_q <= '0;
					count_q  <= '0;
					active_q <= 1'b1;
				end else if (active_q) begin
					offset_q <= next_off;
					count_q  <= count_q + CNT_W'(1);
					if (last) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
		if (leave_s1) begin
			beat_s2 <= beat_d;
		end
	end

	assign beat_valid = v_s2;
	assign beat       = beat_s2;

endmodule

[hdl/ndsag_addr.sv]
module ndsag_addr (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             beat_valid,
	output logic             beat_ready,
	input  ndsag_pkg::beat_t beat,
	input  ndsag_pkg::cfg_t  sizes,
	output logic             elem_valid,
	input  logic             elem_ready,
	output ndsag_pkg::elem_t elem
);
	import ndsag_pkg::*;

	// stage 3
	logic                             v_s3;
	logic                             start_s3;
	logic                             idle_s3;
	logic                             last_s3;
	logic [REGION_W-1:0]              region_s3;
	logic [VOL_W-1:0]                 vol_s3;
	logic [MY_W-1:0]                  my_s3;
	logic [DXY_W-1:0]                 dxy_s3;
	logic [NAXES-1:0][COORD_BITS-1:0] sc_s3;
	logic [NAXES-1:0][COORD_BITS-1:0] off_s3;
	logic [CNT_W-1:0]                 cnt_s3;

	// stage 4
	logic                             v_s4;
	logic                             start_s4;
	logic                             idle_s4;
	logic                             last_s4;
	logic [REGION_W+VOL_LO-1:0]       plo_s4;
	logic [REGION_W+VOL_W-VOL_LO-1:0] phi_s4;
	logic [SXY_W-1:0]                 sxy_s4;
	logic [SRC_W-1:0]                 mz_s4;
	logic [NAXES-1:0][COORD_BITS-1:0] sc_s4;
	logic [NAXES-1:0][COORD_BITS-1:0] off_s4;
	logic [CNT_W-1:0]                 cnt_s4;

	logic                             out_valid_q;
	elem_t                            elem_q;
	logic [DST_W-1:0]                 dst_base_q;

	logic                             out_free;
	logic                             leave_s4;
	logic                             take_s4;
	logic                             leave_s3;
	logic                             take_s3;
	logic [3*SIZE_W-1:0]              vol_full;
	logic [BXY_W-1:0]                 dxy_full;
	logic [MY_W-1:0]                  my_d;
	logic [REGION_W+VOL_LO-1:0]       plo_d;
	logic [REGION_W+VOL_W-VOL_LO-1:0] phi_d;
	logic [COORD_BITS+DXY_W-1:0]      mz_full;
	logic [SXY_W-1:0]                 sxy_d;
	elem_t                            elem_d;

	// starts never take the output slot, so they drain from stage 4 unconditionally
	assign out_free   = !out_valid_q || elem_ready;
	assign leave_s4   = v_s4 && (start_s4 || out_free);
	assign take_s4    = !v_s4 || leave_s4;
	assign leave_s3   = v_s3 && take_s4;
	assign take_s3    = !v_s3 || leave_s3;
	assign beat_ready = take_s3;

	assign vol_full = beat.bxy * beat.bz;
	assign dxy_full = sizes.data_size[0] * sizes.data_size[1];
	assign my_d     = beat.sc[1] * sizes.data_size[0];

	assign plo_d   = region_s3 * vol_s3[VOL_LO-1:0];
	assign phi_d   = region_s3 * vol_s3[VOL_W-1:VOL_LO];
	assign mz_full = sc_s3[2] * dxy_s3;
	assign sxy_d   = SXY_W'(sc_s3[0]) + SXY_W'(my_s3);

	always_comb begin
		elem_d              = '0;
		elem_d.idle_flag    = idle_s4;
		elem_d.src_index    = SRC_W'(sxy_s4) + mz_s4;
		elem_d.dst_index    = idle_s4 ? '0 : dst_base_q + DST_W'(cnt_s4);
		elem_d.src_x        = sc_s4[0];
		elem_d.src_y        = sc_s4[1];
		elem_d.src_z        = sc_s4[2];
		elem_d.box_x        = off_s4[0];
		elem_d.box_y        = off_s4[1];
		elem_d.box_z        = off_s4[2];
		elem_d.last_element = last_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			dst_base_q  <= '0;
		end else begin
			if (take_s3) begin
				v_s3 <= beat_valid;
			end
			if (take_s4) begin
				v_s4 <= leave_s3;
			end
			if (leave_s4 && start_s4) begin
				dst_base_q <= DST_W'(plo_s4) +
					{phi_s4[DST_W-VOL_LO-1:0], {VOL_LO{1'b0}}};
			end
			if (leave_s4 && !start_s4) begin
				out_valid_q <= 1'b1;
			end else if (elem_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat_valid && take_s3) begin
			start_s3  <= beat.is_start;
			idle_s3   <= beat.idle;
			last_s3   <= beat.last;
			region_s3 <= beat.region;
			vol_s3    <= vol_full[VOL_W-1:0];
			my_s3     <= my_d;
			dxy_s3    <= dxy_full[DXY_W-1:0];
			sc_s3     <= beat.sc;
			off_s3    <= beat.off;
			cnt_s3    <= beat.count;
		end
		if (leave_s3) begin
			start_s4 <= start_s3;
			idle_s4  <= idle_s3;
			last_s4  <= last_s3;
			plo_s4   <= plo_d;
			phi_s4   <= phi_d;
			sxy_s4   <= sxy_d;
			mz_s4    <= mz_full[SRC_W-1:0];
			sc_s4    <= sc_s3;
			off_s4   <= off_s3;
			cnt_s4   <= cnt_s3;
		end
		if (leave_s4 && !start_s4) begin
			elem_q <= elem_d;
		end
	end

	assign elem_valid = out_valid_q;
	assign elem       = elem_q;

endmodule

[hdl/nd_subregion_address_generator_unit.sv]
// Crop address generator for a column-major volume (axis zero fastest). A start beat
// (command 0) places a box around a Q.FRAC_BITS center on each axis, clamped to the data,
// and produces no output; each step beat (command 1) then yields one box element: its
// source linear index, its destination index (region times box volume plus element
// number), source and box coordinates and a last flag. A step with no open region yields
// a beat with only idle_flag set. One beat of either kind is accepted every clock while the
// output is not stalled by elem_ready. A step passes through a five-register pipeline
// (input, walk counters, two multiplier stages, output). The walk counters are the only
// loop, fed back from their own registers. Sizes of 0 act as 1, sizes above 4096 act as
// 4096; write the size registers only while no beat is in flight.
module nd_subregion_address_generator_unit #(
	parameter int DIMS      = 3,
	parameter int FRAC_BITS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  ndsag_pkg::cmd_t                 cmd,
	output logic                            elem_valid,
	input  logic                            elem_ready,
	output ndsag_pkg::elem_t                elem,
	input  logic                            cfg_we,
	input  logic [ndsag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ndsag_pkg::REG_W-1:0]     cfg_data
);
	import ndsag_pkg::*;

	cfg_t  sizes;
	logic  beat_valid;
	logic  beat_ready;
	beat_t beat;

	ndsag_cfg #(
		.DIMS(DIMS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sizes    (sizes)
	);

	ndsag_seq #(
		.FRAC_BITS(FRAC_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.sizes     (sizes),
		.beat_valid(beat_valid),
		.beat_ready(beat_ready),
		.beat      (beat)
	);

	ndsag_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_valid(beat_valid),
		.beat_ready(beat_ready),
		.beat      (beat),
		.sizes     (sizes),
		.elem_valid(elem_valid),
		.elem_ready(elem_ready),
		.elem      (elem)
	);

endmodule
